FILE: rtl/tsg_pkg.sv
// shared types, widths and codes of the triangle span generator
`timescale 1ns / 1ps
`default_nettype none

package tsg_pkg;

    // coordinate and fixed point format
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int EDGE_BITS  = 32;

    // divider magnitude covers both dx << FRAC_BITS and the split product
    localparam int DIV_MAG_BITS = (COORD_BITS + FRAC_BITS > 2 * COORD_BITS) ?
                                  (COORD_BITS + FRAC_BITS) : (2 * COORD_BITS);
    localparam int DIV_BITS     = DIV_MAG_BITS + 1;
    localparam int WIDE_BITS    = (DIV_BITS > EDGE_BITS + 1) ? DIV_BITS : (EDGE_BITS + 1);

    // configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_A_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_A_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_B_X = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_B_Y = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_C_X = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_C_Y = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_FILL_COLOR = 3'd6;

    typedef logic signed [COORD_BITS-1:0]   coord_t;
    typedef logic signed [COORD_BITS:0]     dx_t;
    typedef logic signed [2*COORD_BITS+1:0] prod_t;
    typedef logic signed [DIV_BITS-1:0]     dvd_t;
    typedef logic signed [EDGE_BITS-1:0]    edge_t;
    typedef logic signed [WIDE_BITS-1:0]    wide_t;

    localparam coord_t COORD_MAX = coord_t'({1'b0, {(COORD_BITS-1){1'b1}}});
    localparam coord_t COORD_MIN = coord_t'({1'b1, {(COORD_BITS-1){1'b0}}});
    localparam edge_t  EDGE_MAX  = 32'sh7FFF_FFFF;
    localparam edge_t  EDGE_MIN  = 32'sh8000_0000;

    // divider request and response
    typedef struct packed {
        logic                  start;
        dvd_t                  dividend;
        logic [COORD_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        dvd_t quotient;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT,
        ST_SETUP,
        ST_SPLIT,
        ST_SLOPE,
        ST_WAIT_FIRST,
        ST_WAIT_SECOND,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TOP,
        PH_BOT
    } phase_t;

endpackage

`default_nettype wire

FILE: rtl/triangle_span_generator_unit.sv
// triangle span generator: sorts vertices, sets up edges, emits one span per transaction
`timescale 1ns / 1ps
`default_nettype none

//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------------
//  s_       | in        | s_valid / s_ready  | s_restart
//  m_       | out       | m_valid / m_ready  | m_span_row, m_span_x_first, m_span_x_second,
//           |           |                    | m_span_color, m_last_span
//  cfg_     | in        | cfg_we (no wait)   | cfg_addr, cfg_wdata
//
//  an advance transaction: accept, then the emit step puts the span in the output register once it is free
//  a restart sorts the vertices, sets up the edges, then runs one divider pass for each
//  slope (none for a one-row triangle) and one more for the split point when split
//  the transaction that leaves the middle row of a split triangle adds two divider
//  passes before the next accept
//  s_ready is high only while the sequencer waits; a span held in the output register
//  does not block the next accept, only the next emit
//  reset (aresetn low, synchronous) clears the sequencer, the phase, the output valid and the config registers

module triangle_span_generator_unit
    import tsg_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // configuration
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
    // input channel
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_restart,
    // result channel
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output coord_t                        m_span_row,
    output coord_t                        m_span_x_first,
    output coord_t                        m_span_x_second,
    output logic [31:0]                   m_span_color,
    output logic                          m_last_span
);

    // saturate a wide signed value to the 32-bit edge range
    function automatic edge_t sat_edge(input wide_t v);
        wide_t hi;
        wide_t lo;
        hi = wide_t'(EDGE_MAX);
        lo = wide_t'(EDGE_MIN);
        if (v > hi) begin
            return EDGE_MAX;
        end else if (v < lo) begin
            return EDGE_MIN;
        end
        return v[EDGE_BITS-1:0];
    endfunction

    function automatic edge_t make_edge(input coord_t x);
        return sat_edge(wide_t'(x) <<< FRAC_BITS);
    endfunction

    // edge to pixel: truncate toward zero, clamp to coordinate range
    function automatic coord_t to_coord(input edge_t ev);
        logic signed [EDGE_BITS:0] t;
        logic signed [EDGE_BITS:0] hi;
        logic signed [EDGE_BITS:0] lo;
        hi = (EDGE_BITS+1)'(COORD_MAX);
        lo = (EDGE_BITS+1)'(COORD_MIN);
        t  = (EDGE_BITS+1)'(ev) >>> FRAC_BITS;
        if (ev[EDGE_BITS-1] && (ev[FRAC_BITS-1:0] != '0)) begin
            t = t + $signed((EDGE_BITS+1)'(1));
        end
        if (t > hi) begin
            return COORD_MAX;
        end else if (t < lo) begin
            return COORD_MIN;
        end
        return t[COORD_BITS-1:0];
    endfunction

    // configuration registers
    coord_t      cfg_vx_reg [3];
    coord_t      cfg_vy_reg [3];
    logic [31:0] fill_color_reg;

    // sequencer and triangle state
    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [1:0]  sort_cnt_reg, sort_cnt_next;
    logic        emit_after_reg, emit_after_next;
    coord_t      sx_reg [3];
    coord_t      sx_next [3];
    coord_t      sy_reg [3];
    coord_t      sy_next [3];
    coord_t      split_x_reg, split_x_next;
    coord_t      row_reg, row_next;
    edge_t       edge_first_reg, edge_first_next;
    edge_t       edge_second_reg, edge_second_next;
    edge_t       slope_first_reg, slope_first_next;
    edge_t       slope_second_reg, slope_second_next;
    dx_t         dx_first_reg, dx_first_next;
    dx_t         dx_second_reg, dx_second_next;
    logic [COORD_BITS-1:0] dy_reg, dy_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    coord_t      m_row_reg, m_row_next;
    coord_t      m_xf_reg, m_xf_next;
    coord_t      m_xs_reg, m_xs_next;
    logic [31:0] m_color_reg, m_color_next;
    logic        m_last_reg, m_last_next;

    // shared divider
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    // compare-swap operands: pair (1,2) on the middle sort step, else (0,1)
    logic        pair_hi;
    coord_t      pa_x, pa_y, pb_x, pb_y;

    dx_t         dx_10, dx_20, dx_21, dx_2s;
    dx_t         dy_10, dy_20, dy_21;
    prod_t       split_num;
    logic        at_mid;

    tsg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                cfg_vx_reg[i] <= '0;
                cfg_vy_reg[i] <= '0;
            end
            fill_color_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_VERTEX_A_X: cfg_vx_reg[0] <= cfg_wdata[COORD_BITS-1:0];
                REG_VERTEX_A_Y: cfg_vy_reg[0] <= cfg_wdata[COORD_BITS-1:0];
                REG_VERTEX_B_X: cfg_vx_reg[1] <= cfg_wdata[COORD_BITS-1:0];
                REG_VERTEX_B_Y: cfg_vy_reg[1] <= cfg_wdata[COORD_BITS-1:0];
                REG_VERTEX_C_X: cfg_vx_reg[2] <= cfg_wdata[COORD_BITS-1:0];
                REG_VERTEX_C_Y: cfg_vy_reg[2] <= cfg_wdata[COORD_BITS-1:0];
                REG_FILL_COLOR: fill_color_reg <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    assign pair_hi = (sort_cnt_reg == 2'd1);
    assign pa_x    = pair_hi ? sx_reg[1] : sx_reg[0];
    assign pa_y    = pair_hi ? sy_reg[1] : sy_reg[0];
    assign pb_x    = pair_hi ? sx_reg[2] : sx_reg[1];
    assign pb_y    = pair_hi ? sy_reg[2] : sy_reg[1];

    assign dx_10 = dx_t'(sx_reg[1]) - dx_t'(sx_reg[0]);
    assign dx_20 = dx_t'(sx_reg[2]) - dx_t'(sx_reg[0]);
    assign dx_21 = dx_t'(sx_reg[2]) - dx_t'(sx_reg[1]);
    assign dx_2s = dx_t'(sx_reg[2]) - dx_t'(split_x_reg);
    assign dy_10 = dx_t'(sy_reg[1]) - dx_t'(sy_reg[0]);
    assign dy_20 = dx_t'(sy_reg[2]) - dx_t'(sy_reg[0]);
    assign dy_21 = dx_t'(sy_reg[2]) - dx_t'(sy_reg[1]);

    assign split_num = prod_t'(dx_20) * prod_t'(dy_10);
    assign at_mid    = (row_reg == sy_reg[1]);

    always_comb begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        sort_cnt_next     = sort_cnt_reg;
        emit_after_next   = emit_after_reg;
        for (int i = 0; i < 3; i++) begin
            sx_next[i] = sx_reg[i];
            sy_next[i] = sy_reg[i];
        end
        split_x_next      = split_x_reg;
        row_next          = row_reg;
        edge_first_next   = edge_first_reg;
        edge_second_next  = edge_second_reg;
        slope_first_next  = slope_first_reg;
        slope_second_next = slope_second_reg;
        dx_first_next     = dx_first_reg;
        dx_second_next    = dx_second_reg;
        dy_next           = dy_reg;

        m_valid_next      = m_valid_reg && !m_ready;
        m_row_next        = m_row_reg;
        m_xf_next         = m_xf_reg;
        m_xs_next         = m_xs_reg;
        m_color_next      = m_color_reg;
        m_last_next       = m_last_reg;

        div_req.start     = 1'b0;
        div_req.dividend  = dvd_t'(dx_first_reg) <<< FRAC_BITS;
        div_req.divisor   = dy_reg;
        s_ready           = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_restart) begin
                        // new triangle drops the triangle in progress; a span in the output register stays
                        for (int i = 0; i < 3; i++) begin
                            sx_next[i] = cfg_vx_reg[i];
                            sy_next[i] = cfg_vy_reg[i];
                        end
                        sort_cnt_next = 2'd0;
                        state_next    = ST_SORT;
                    end else if (phase_reg != PH_IDLE) begin
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_SORT: begin
                // swap only on strictly greater y
                if (pa_y > pb_y) begin
                    if (pair_hi) begin
                        sx_next[1] = pb_x;
                        sy_next[1] = pb_y;
                        sx_next[2] = pa_x;
                        sy_next[2] = pa_y;
                    end else begin
                        sx_next[0] = pb_x;
                        sy_next[0] = pb_y;
                        sx_next[1] = pa_x;
                        sy_next[1] = pa_y;
                    end
                end
                sort_cnt_next = sort_cnt_reg + 2'd1;
                if (sort_cnt_reg == 2'd2) begin
                    state_next = ST_SETUP;
                end
            end

            ST_SETUP: begin
                emit_after_next = 1'b1;
                if (sy_reg[1] == sy_reg[2]) begin
                    // flat bottom only
                    split_x_next     = sx_reg[2];
                    edge_first_next  = make_edge(sx_reg[0]);
                    edge_second_next = make_edge(sx_reg[0]);
                    row_next         = sy_reg[0];
                    phase_next       = PH_TOP;
                    dx_first_next    = dx_10;
                    dx_second_next   = dx_20;
                    dy_next          = dy_10[COORD_BITS-1:0];
                    state_next       = ST_SLOPE;
                end else if (sy_reg[0] == sy_reg[1]) begin
                    // flat top only, walks up from the lowest vertex
                    split_x_next     = sx_reg[2];
                    edge_first_next  = make_edge(sx_reg[2]);
                    edge_second_next = make_edge(sx_reg[2]);
                    row_next         = sy_reg[2];
                    phase_next       = PH_BOT;
                    dx_first_next    = dx_20;
                    dx_second_next   = dx_21;
                    dy_next          = dy_21[COORD_BITS-1:0];
                    state_next       = ST_SLOPE;
                end else begin
                    // split triangle: split x on the middle row first
                    edge_first_next  = make_edge(sx_reg[0]);
                    edge_second_next = make_edge(sx_reg[0]);
                    row_next         = sy_reg[0];
                    phase_next       = PH_TOP;
                    dx_first_next    = dx_10;
                    dy_next          = dy_10[COORD_BITS-1:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = dvd_t'(split_num);
                    div_req.divisor  = dy_20[COORD_BITS-1:0];
                    state_next       = ST_SPLIT;
                end
            end

            ST_SPLIT: begin
                if (div_rsp.done) begin
                    // quotient lies between zero and x2 - x0, so it fits
                    split_x_next   = coord_t'(div_rsp.quotient) + sx_reg[0];
                    dx_second_next = dx_t'(div_rsp.quotient);
                    state_next     = ST_SLOPE;
                end
            end

            ST_SLOPE: begin
                if (dy_reg == '0) begin
                    // single row triangle
                    slope_first_next  = '0;
                    slope_second_next = '0;
                    state_next        = emit_after_reg ? ST_EMIT : ST_IDLE;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = ST_WAIT_FIRST;
                end
            end

            ST_WAIT_FIRST: begin
                div_req.dividend = dvd_t'(dx_second_reg) <<< FRAC_BITS;
                if (div_rsp.done) begin
                    slope_first_next = sat_edge(wide_t'(div_rsp.quotient));
                    div_req.start    = 1'b1;
                    state_next       = ST_WAIT_SECOND;
                end
            end

            ST_WAIT_SECOND: begin
                if (div_rsp.done) begin
                    slope_second_next = sat_edge(wide_t'(div_rsp.quotient));
                    state_next        = emit_after_reg ? ST_EMIT : ST_IDLE;
                end
            end

            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_row_next   = row_reg;
                    m_xf_next    = to_coord(edge_first_reg);
                    m_xs_next    = to_coord(edge_second_reg);
                    m_color_next = fill_color_reg;
                    m_last_next  = 1'b0;
                    state_next   = ST_IDLE;
                    case (phase_reg)
                        PH_TOP: begin
                            if (at_mid) begin
                                if (sy_reg[2] != sy_reg[1]) begin
                                    // middle row again from below, new slopes
                                    edge_first_next  = make_edge(sx_reg[2]);
                                    edge_second_next = make_edge(sx_reg[2]);
                                    row_next         = sy_reg[2];
                                    phase_next       = PH_BOT;
                                    dx_first_next    = dx_21;
                                    dx_second_next   = dx_2s;
                                    dy_next          = dy_21[COORD_BITS-1:0];
                                    emit_after_next  = 1'b0;
                                    state_next       = ST_SLOPE;
                                end else begin
                                    phase_next  = PH_IDLE;
                                    m_last_next = 1'b1;
                                end
                            end else begin
                                edge_first_next  = sat_edge(wide_t'(edge_first_reg) +
                                                            wide_t'(slope_first_reg));
                                edge_second_next = sat_edge(wide_t'(edge_second_reg) +
                                                            wide_t'(slope_second_reg));
                                row_next         = row_reg + coord_t'(1);
                            end
                        end
                        PH_BOT: begin
                            if (at_mid) begin
                                phase_next  = PH_IDLE;
                                m_last_next = 1'b1;
                            end else begin
                                edge_first_next  = sat_edge(wide_t'(edge_first_reg) -
                                                            wide_t'(slope_first_reg));
                                edge_second_next = sat_edge(wide_t'(edge_second_reg) -
                                                            wide_t'(slope_second_reg));
                                row_next         = row_reg - coord_t'(1);
                            end
                        end
                        default: begin
                            m_valid_next = m_valid_reg && !m_ready;
                        end
                    endcase
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_IDLE;
            sort_cnt_reg   <= '0;
            emit_after_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            sort_cnt_reg   <= sort_cnt_next;
            emit_after_reg <= emit_after_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            sx_reg[i] <= sx_next[i];
            sy_reg[i] <= sy_next[i];
        end
        split_x_reg      <= split_x_next;
        row_reg          <= row_next;
        edge_first_reg   <= edge_first_next;
        edge_second_reg  <= edge_second_next;
        slope_first_reg  <= slope_first_next;
        slope_second_reg <= slope_second_next;
        dx_first_reg     <= dx_first_next;
        dx_second_reg    <= dx_second_next;
        dy_reg           <= dy_next;
        m_row_reg        <= m_row_next;
        m_xf_reg         <= m_xf_next;
        m_xs_reg         <= m_xs_next;
        m_color_reg      <= m_color_next;
        m_last_reg       <= m_last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_span_row      = m_row_reg;
    assign m_span_x_first  = m_xf_reg;
    assign m_span_x_second = m_xs_reg;
    assign m_span_color    = m_color_reg;
    assign m_last_span     = m_last_reg;

    // a new span only ever comes out of the emit step
    a_emit_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("span appeared outside the emit step");

    // a zero row difference only occurs for a one-row triangle during restart
    a_zero_dy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SLOPE && dy_reg == '0) |->
        (sy_reg[0] == sy_reg[2] && emit_after_reg))
        else $error("zero row difference outside a one-row triangle");

    // split point lands between the top and bottom vertex x
    a_split_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SPLIT && div_rsp.done) |=>
        ((split_x_reg >= sx_reg[0] && split_x_reg <= sx_reg[2]) ||
         (split_x_reg <= sx_reg[0] && split_x_reg >= sx_reg[2])))
        else $error("split x outside the long edge");

    // an advance with no triangle in progress leaves the sequencer waiting
    a_idle_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_restart && phase_reg == PH_IDLE) |=>
        (state_reg == ST_IDLE))
        else $error("advance without a triangle left the wait state");

endmodule

`default_nettype wire

FILE: rtl/tsg_div.sv
// serial restoring divider: signed dividend, non-negative divisor, truncating
`timescale 1ns / 1ps
`default_nettype none

module tsg_div
    import tsg_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int CNT_BITS = $clog2(DIV_MAG_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIV_MAG_BITS - 1);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic                    neg_reg, neg_next;
    logic [CNT_BITS-1:0]     cnt_reg, cnt_next;
    logic [COORD_BITS-1:0]   rem_reg, rem_next;
    logic [COORD_BITS-1:0]   dvs_reg, dvs_next;
    logic [DIV_MAG_BITS-1:0] quo_reg, quo_next;

    dvd_t                    abs_val;
    logic [COORD_BITS:0]     trial;
    logic [COORD_BITS:0]     diff;
    logic                    fits;
    dvd_t                    mag_s;

    assign abs_val = req.dividend[DIV_BITS-1] ? -req.dividend : req.dividend;
    assign trial   = {rem_reg, quo_reg[DIV_MAG_BITS-1]};
    assign diff    = trial - {1'b0, dvs_reg};
    assign fits    = trial >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            neg_next  = req.dividend[DIV_BITS-1];
            quo_next  = abs_val[DIV_MAG_BITS-1:0];
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // one quotient bit a cycle
            rem_next = fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
            quo_next = {quo_reg[DIV_MAG_BITS-2:0], fits};
            cnt_next = cnt_reg + CNT_BITS'(1);
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign mag_s        = dvd_t'({1'b0, quo_reg});
    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -mag_s : mag_s;

endmodule

`default_nettype wire
